@@ rtl/obeu_pkg.sv @@
package obeu_pkg;

  // opmask file geometry
  localparam int MASK_REGS = 8;
  localparam int IDX_W     = $clog2(MASK_REGS);
  localparam int BYTE_W    = 8;

  // operation codes
  localparam logic [3:0] OP_ADD      = 4'd0;
  localparam logic [3:0] OP_AND      = 4'd1;
  localparam logic [3:0] OP_ANDN     = 4'd2;
  localparam logic [3:0] OP_LOAD     = 4'd3;
  localparam logic [3:0] OP_MOVE     = 4'd4;
  localparam logic [3:0] OP_STORE    = 4'd5;
  localparam logic [3:0] OP_FROM_GPR = 4'd6;
  localparam logic [3:0] OP_TO_GPR   = 4'd7;
  localparam logic [3:0] OP_NOT      = 4'd8;
  localparam logic [3:0] OP_OR       = 4'd9;
  localparam logic [3:0] OP_ORTEST   = 4'd10;
  localparam logic [3:0] OP_SHL      = 4'd11;
  localparam logic [3:0] OP_SHR      = 4'd12;
  localparam logic [3:0] OP_XNOR     = 4'd13;
  localparam logic [3:0] OP_XOR      = 4'd14;
  localparam logic [3:0] OP_TEST     = 4'd15;

  // result of one executed mask instruction
  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              mask_written;
    logic              external_written;
    logic              flags_valid;
    logic              zero_flag;
    logic              carry_flag;
  } res_t;

endpackage

@@ rtl/obeu_ram.sv @@
module obeu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, two registered read ports (read returns old data on collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

@@ rtl/obeu_alu.sv @@
module obeu_alu (
  input  logic [3:0]                 cmd,
  input  logic [obeu_pkg::BYTE_W-1:0] a,
  input  logic [obeu_pkg::BYTE_W-1:0] b,
  input  logic [7:0]                 shift_count,
  input  logic [obeu_pkg::BYTE_W-1:0] external_byte,
  output obeu_pkg::res_t             res
);

  logic [obeu_pkg::BYTE_W-1:0] or_ab;
  logic                        big_shift;

  assign or_ab     = a | b;
  assign big_shift = (shift_count >= 8'd8);

  // byte-wide operation select
  always_comb begin
    res                  = '0;
    res.mask_written     = 1'b1;
    unique case (cmd)
      obeu_pkg::OP_ADD:      res.value = a + b;
      obeu_pkg::OP_AND:      res.value = a & b;
      obeu_pkg::OP_ANDN:     res.value = ~a & b;
      obeu_pkg::OP_LOAD:     res.value = external_byte;
      obeu_pkg::OP_MOVE:     res.value = a;
      obeu_pkg::OP_STORE,
      obeu_pkg::OP_TO_GPR: begin
        res.value            = a;
        res.mask_written     = 1'b0;
        res.external_written = 1'b1;
      end
      obeu_pkg::OP_FROM_GPR: res.value = external_byte;
      obeu_pkg::OP_NOT:      res.value = ~a;
      obeu_pkg::OP_OR:       res.value = or_ab;
      obeu_pkg::OP_ORTEST: begin
        res.mask_written = 1'b0;
        res.flags_valid  = 1'b1;
        res.zero_flag    = (or_ab == '0);
        res.carry_flag   = (or_ab == '1);
      end
      obeu_pkg::OP_SHL:      res.value = big_shift ? '0 : (a << shift_count[2:0]);
      obeu_pkg::OP_SHR:      res.value = big_shift ? '0 : (a >> shift_count[2:0]);
      obeu_pkg::OP_XNOR:     res.value = ~(a ^ b);
      obeu_pkg::OP_XOR:      res.value = a ^ b;
      obeu_pkg::OP_TEST: begin
        res.mask_written = 1'b0;
        res.flags_valid  = 1'b1;
        res.zero_flag    = ((a & b) == '0);
        res.carry_flag   = ((~a & b) == '0);
      end
    endcase
  end

endmodule

@@ rtl/opmask_byte_execution_unit.sv @@
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready   | cmd, dest_index, first_source, second_source,
//         |           |                       | shift_count, external_byte
// out     | output    | out_valid / out_ready | result_value, mask_written, external_written,
//         |           |                       | flags_valid, zero_flag, carry_flag
//
// One word per cycle unless the output stalls; each word is registered in stage 1, then in stage 2.
// Stage 1 registers the instruction and reads both sources from the two-port mask RAM;
// stage 2 executes, writes the mask RAM and loads the output register.
// A write landing on the same edge as the next read is forwarded from a bypass register.
// rst_n (synchronous) empties both stages and marks all eight mask registers as zero.
// A stalled output holds stage 2 and, through it, stage 1; in_ready drops only then.
module opmask_byte_execution_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [3:0] in_cmd,
  input  logic [2:0] in_dest_index,
  input  logic [2:0] in_first_source,
  input  logic [2:0] in_second_source,
  input  logic [7:0] in_shift_count,
  input  logic [7:0] in_external_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_result_value,
  output logic       out_mask_written,
  output logic       out_external_written,
  output logic       out_flags_valid,
  output logic       out_zero_flag,
  output logic       out_carry_flag
);

  localparam int IW = obeu_pkg::IDX_W;
  localparam int BW = obeu_pkg::BYTE_W;

  // stage 1 registers
  logic          s1_v_r, s1_v_nxt;
  logic [3:0]    cmd_r;
  logic [IW-1:0] dest_r, src_a_r, src_b_r;
  logic [7:0]    cnt_r, ext_r;
  logic          a_vld_r, b_vld_r;

  // bypass of the write that coincides with the RAM read
  logic          byp_v_r;
  logic [IW-1:0] byp_addr_r;
  logic [BW-1:0] byp_data_r;

  // entry valid bits, cleared at reset
  logic [obeu_pkg::MASK_REGS-1:0] vld_r, vld_nxt;

  // output register
  logic           out_v_r, out_v_nxt;
  obeu_pkg::res_t out_r;

  logic           in_acc, adv, wr_en;
  logic [BW-1:0]  ram_a, ram_b, op_a, op_b;
  obeu_pkg::res_t res;

  // handshake and stage advance
  assign adv      = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !s1_v_r || adv;
  assign in_acc   = in_valid && in_ready;
  assign wr_en    = adv && res.mask_written;

  assign s1_v_nxt  = in_acc ? 1'b1 : (adv ? 1'b0 : s1_v_r);
  assign out_v_nxt = adv ? 1'b1 : (out_ready ? 1'b0 : out_v_r);

  always_comb begin
    vld_nxt = vld_r;
    if (wr_en) begin
      vld_nxt[dest_r] = 1'b1;
    end
  end

  // mask file storage
  obeu_ram #(
    .WIDTH (BW),
    .DEPTH (obeu_pkg::MASK_REGS)
  ) u_mask_ram (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (dest_r),
    .wdata   (res.value),
    .re      (in_acc),
    .raddr_a (in_first_source[IW-1:0]),
    .raddr_b (in_second_source[IW-1:0]),
    .rdata_a (ram_a),
    .rdata_b (ram_b)
  );

  // operand select: bypass, then RAM, then reset value
  always_comb begin
    if (byp_v_r && (byp_addr_r == src_a_r)) begin
      op_a = byp_data_r;
    end else begin
      op_a = a_vld_r ? ram_a : '0;
    end
    if (byp_v_r && (byp_addr_r == src_b_r)) begin
      op_b = byp_data_r;
    end else begin
      op_b = b_vld_r ? ram_b : '0;
    end
  end

  obeu_alu u_alu (
    .cmd           (cmd_r),
    .a             (op_a),
    .b             (op_b),
    .shift_count   (cnt_r),
    .external_byte (ext_r),
    .res           (res)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      byp_v_r <= 1'b0;
      vld_r   <= '0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
      vld_r   <= vld_nxt;
      if (in_acc) begin
        byp_v_r <= wr_en;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r      <= in_cmd;
      dest_r     <= in_dest_index[IW-1:0];
      src_a_r    <= in_first_source[IW-1:0];
      src_b_r    <= in_second_source[IW-1:0];
      cnt_r      <= in_shift_count;
      ext_r      <= in_external_byte;
      a_vld_r    <= vld_r[in_first_source[IW-1:0]];
      b_vld_r    <= vld_r[in_second_source[IW-1:0]];
      byp_addr_r <= dest_r;
      byp_data_r <= res.value;
    end
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_valid            = out_v_r;
  assign out_result_value     = out_r.value;
  assign out_mask_written     = out_r.mask_written;
  assign out_external_written = out_r.external_written;
  assign out_flags_valid      = out_r.flags_valid;
  assign out_zero_flag        = out_r.zero_flag;
  assign out_carry_flag       = out_r.carry_flag;

  // checks
  a_no_dual_dest: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_mask_written && out_external_written))
    else $error("result both written to mask and sent out");

  a_test_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_flags_valid) |->
      (out_result_value == '0 && !out_mask_written && !out_external_written))
    else $error("test result carries a value or a write");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !adv) |=> s1_v_r)
    else $error("stalled instruction lost from stage 1");

  a_vld_set: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> vld_r[$past(dest_r)])
    else $error("mask write did not mark entry valid");

endmodule

@@ sim/opmask_result_checker.sv @@
`timescale 1ns / 100ps

// Watches both channels of the opmask unit, predicts each result word from
// a shadow copy of the mask file and compares it against what comes out.
module opmask_result_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [3:0]        in_cmd,
  input  logic [2:0]        in_dest_index,
  input  logic [2:0]        in_first_source,
  input  logic [2:0]        in_second_source,
  input  logic [7:0]        in_shift_count,
  input  logic [7:0]        in_external_byte,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [7:0]        out_result_value,
  input  logic              out_mask_written,
  input  logic              out_external_written,
  input  logic              out_flags_valid,
  input  logic              out_zero_flag,
  input  logic              out_carry_flag,
  output int unsigned       fail_count,
  output int unsigned       queued_words
);

  logic [obeu_pkg::BYTE_W-1:0] shadow_masks [obeu_pkg::MASK_REGS];
  obeu_pkg::res_t              expected_results [$];
  int unsigned                 mismatch_count = 0;
  int unsigned                 queued_count = 0;

  assign fail_count   = mismatch_count;
  assign queued_words = queued_count;

  // execute one mask instruction on source bytes a and b
  function automatic obeu_pkg::res_t execute_opmask(input logic [3:0] op,
                                                    input logic [7:0] a,
                                                    input logic [7:0] b,
                                                    input logic [7:0] cnt,
                                                    input logic [7:0] ext);
    obeu_pkg::res_t r;
    logic [7:0]     t;
    r = '0;
    r.mask_written = 1'b1;
    case (op)
      obeu_pkg::OP_ADD:      r.value = a + b;
      obeu_pkg::OP_AND:      r.value = a & b;
      obeu_pkg::OP_ANDN:     r.value = ~a & b;
      obeu_pkg::OP_LOAD:     r.value = ext;
      obeu_pkg::OP_MOVE:     r.value = a;
      obeu_pkg::OP_FROM_GPR: r.value = ext;
      obeu_pkg::OP_NOT:      r.value = ~a;
      obeu_pkg::OP_OR:       r.value = a | b;
      obeu_pkg::OP_XNOR:     r.value = ~(a ^ b);
      obeu_pkg::OP_XOR:      r.value = a ^ b;
      // counts of 8 and up flush the byte
      obeu_pkg::OP_SHL:      r.value = (cnt < 8'd8) ? (a << cnt[2:0]) : 8'h00;
      obeu_pkg::OP_SHR:      r.value = (cnt < 8'd8) ? (a >> cnt[2:0]) : 8'h00;
      obeu_pkg::OP_STORE, obeu_pkg::OP_TO_GPR: begin
        r.value            = a;
        r.mask_written     = 1'b0;
        r.external_written = 1'b1;
      end
      obeu_pkg::OP_ORTEST: begin
        t              = a | b;
        r.mask_written = 1'b0;
        r.flags_valid  = 1'b1;
        r.zero_flag    = (t == 8'h00);
        r.carry_flag   = (t == 8'hff);
      end
      default: begin  // test
        r.mask_written = 1'b0;
        r.flags_valid  = 1'b1;
        r.zero_flag    = ((a & b) == 8'h00);
        r.carry_flag   = ((~a & b) == 8'h00);
      end
    endcase
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // compare outgoing words first, then predict the word accepted this edge
  always @(posedge clk) begin
    obeu_pkg::res_t got;
    obeu_pkg::res_t want;
    if (!rst_n) begin
      foreach (shadow_masks[i]) shadow_masks[i] = '0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = {out_result_value, out_mask_written, out_external_written,
               out_flags_valid, out_zero_flag, out_carry_flag};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual %h", $time, got);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("result_value", want.value, got.value);
          check_field("mask_written", want.mask_written, got.mask_written);
          check_field("external_written", want.external_written, got.external_written);
          check_field("flags_valid", want.flags_valid, got.flags_valid);
          check_field("zero_flag", want.zero_flag, got.zero_flag);
          check_field("carry_flag", want.carry_flag, got.carry_flag);
        end
      end
      if (in_valid && in_ready) begin
        want = execute_opmask(in_cmd, shadow_masks[in_first_source],
                              shadow_masks[in_second_source], in_shift_count,
                              in_external_byte);
        if (want.mask_written) shadow_masks[in_dest_index] = want.value;
        expected_results.push_back(want);
      end
    end
    queued_count <= expected_results.size();
  end

endmodule

@@ sim/tb_opmask_byte_execution_unit.sv @@
`timescale 1ns / 100ps

module tb_opmask_byte_execution_unit;

  localparam int RANDOM_WORDS   = 1850;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 10;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [3:0] in_cmd = '0;
  logic [2:0] in_dest_index = '0;
  logic [2:0] in_first_source = '0;
  logic [2:0] in_second_source = '0;
  logic [7:0] in_shift_count = '0;
  logic [7:0] in_external_byte = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_result_value;
  logic       out_mask_written;
  logic       out_external_written;
  logic       out_flags_valid;
  logic       out_zero_flag;
  logic       out_carry_flag;

  int unsigned fail_count;
  int unsigned queued_words;
  int unsigned idle_cycles = 0;
  int          stall_left = 0;
  logic        no_idle = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  opmask_byte_execution_unit i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_cmd               (in_cmd),
    .in_dest_index        (in_dest_index),
    .in_first_source      (in_first_source),
    .in_second_source     (in_second_source),
    .in_shift_count       (in_shift_count),
    .in_external_byte     (in_external_byte),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_result_value     (out_result_value),
    .out_mask_written     (out_mask_written),
    .out_external_written (out_external_written),
    .out_flags_valid      (out_flags_valid),
    .out_zero_flag        (out_zero_flag),
    .out_carry_flag       (out_carry_flag)
  );

  opmask_result_checker i_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_cmd               (in_cmd),
    .in_dest_index        (in_dest_index),
    .in_first_source      (in_first_source),
    .in_second_source     (in_second_source),
    .in_shift_count       (in_shift_count),
    .in_external_byte     (in_external_byte),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_result_value     (out_result_value),
    .out_mask_written     (out_mask_written),
    .out_external_written (out_external_written),
    .out_flags_valid      (out_flags_valid),
    .out_zero_flag        (out_zero_flag),
    .out_carry_flag       (out_carry_flag),
    .fail_count           (fail_count),
    .queued_words         (queued_words)
  );

  // result side backpressure: a fresh random stall after each word, skipped while no_idle is set
  always @(posedge clk) begin
    if (out_valid && out_ready) stall_left = no_idle ? 0 : $urandom_range(0, 4);
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog: no word moving on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("opmask_byte_execution_unit test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // present one instruction word after a random gap, return once accepted
  task automatic send_word(input logic [3:0] op, input logic [2:0] dst,
                           input logic [2:0] src_a, input logic [2:0] src_b,
                           input logic [7:0] cnt, input logic [7:0] ext);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_cmd           <= op;
    in_dest_index    <= dst;
    in_first_source  <= src_a;
    in_second_source <= src_b;
    in_shift_count   <= cnt;
    in_external_byte <= ext;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    logic [3:0] op;
    logic [7:0] ext;
    logic [7:0] cnt;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: seed extremes, then every operation and the corner cases
    send_word(obeu_pkg::OP_LOAD,     3'd0, 3'd5, 3'd6, 8'h3c, 8'hff);
    send_word(obeu_pkg::OP_FROM_GPR, 3'd1, 3'd7, 3'd2, 8'hc3, 8'h00);
    send_word(obeu_pkg::OP_LOAD,     3'd2, 3'd0, 3'd0, 8'h00, 8'h80);
    send_word(obeu_pkg::OP_FROM_GPR, 3'd3, 3'd1, 3'd1, 8'hff, 8'h01);
    send_word(obeu_pkg::OP_ADD,      3'd4, 3'd0, 3'd3, 8'h11, 8'h22);  // wraps to zero
    send_word(obeu_pkg::OP_ADD,      3'd5, 3'd0, 3'd0, 8'h00, 8'h00);
    send_word(obeu_pkg::OP_AND,      3'd6, 3'd0, 3'd2, 8'h00, 8'h5a);
    send_word(obeu_pkg::OP_ANDN,     3'd7, 3'd2, 3'd0, 8'h00, 8'ha5);
    send_word(obeu_pkg::OP_OR,       3'd4, 3'd2, 3'd3, 8'h00, 8'h00);
    send_word(obeu_pkg::OP_XOR,      3'd5, 3'd0, 3'd2, 8'h00, 8'h00);
    send_word(obeu_pkg::OP_XNOR,     3'd6, 3'd1, 3'd3, 8'h00, 8'h00);
    send_word(obeu_pkg::OP_NOT,      3'd7, 3'd1, 3'd4, 8'h00, 8'h00);
    send_word(obeu_pkg::OP_MOVE,     3'd4, 3'd0, 3'd6, 8'h00, 8'h00);
    send_word(obeu_pkg::OP_SHL,      3'd5, 3'd0, 3'd3, 8'd0,  8'h00);
    send_word(obeu_pkg::OP_SHL,      3'd5, 3'd0, 3'd3, 8'd7,  8'h00);
    send_word(obeu_pkg::OP_SHL,      3'd6, 3'd0, 3'd3, 8'd8,  8'h00);   // flushed
    send_word(obeu_pkg::OP_SHR,      3'd6, 3'd2, 3'd3, 8'd7,  8'h00);
    send_word(obeu_pkg::OP_SHR,      3'd7, 3'd0, 3'd3, 8'd255, 8'h00);  // flushed
    send_word(obeu_pkg::OP_STORE,    3'd3, 3'd2, 3'd5, 8'h00, 8'h77);
    send_word(obeu_pkg::OP_TO_GPR,   3'd0, 3'd0, 3'd5, 8'h00, 8'h88);
    send_word(obeu_pkg::OP_ORTEST,   3'd2, 3'd1, 3'd1, 8'h00, 8'h00);   // ZF set
    send_word(obeu_pkg::OP_ORTEST,   3'd0, 3'd2, 3'd6, 8'h00, 8'h00);
    send_word(obeu_pkg::OP_ORTEST,   3'd1, 3'd2, 3'd0, 8'h00, 8'h00);   // CF set
    send_word(obeu_pkg::OP_TEST,     3'd0, 3'd0, 3'd1, 8'h00, 8'h00);   // ZF and CF set
    send_word(obeu_pkg::OP_TEST,     3'd1, 3'd2, 3'd0, 8'h00, 8'h00);   // neither set

    // random: phases of 50 words, some with no idling on either side
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
      // a quarter of the words reload registers to keep contents varied
      if ($urandom_range(0, 3) == 0) begin
        op = $urandom_range(0, 1) ? obeu_pkg::OP_LOAD : obeu_pkg::OP_FROM_GPR;
      end else begin
        op = 4'($urandom_range(0, 15));
      end
      case ($urandom_range(0, 3))
        0: ext = $urandom_range(0, 1) ? 8'hff : 8'h00;
        1: ext = 8'h01 << $urandom_range(0, 7);
        default: ext = 8'($urandom_range(0, 255));
      endcase
      cnt = $urandom_range(0, 1) ? 8'($urandom_range(0, 9)) : 8'($urandom_range(0, 255));
      send_word(op, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                3'($urandom_range(0, 7)), cnt, ext);
    end
    in_valid <= 1'b0;
    no_idle = 1'b0;

    // drain outstanding words, then let the pipe settle
    do @(posedge clk); while (queued_words != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("opmask_byte_execution_unit test passed");
    else $display("opmask_byte_execution_unit test failed");
    $finish;
  end

endmodule

@@ opmask_byte_execution_unit.f @@
rtl/obeu_pkg.sv
rtl/obeu_ram.sv
rtl/obeu_alu.sv
rtl/opmask_byte_execution_unit.sv
sim/opmask_result_checker.sv
sim/tb_opmask_byte_execution_unit.sv
